FILE: design/cpts_pkg.sv
// Shared types and constants of the counter priority task scheduler.
`timescale 1ns / 1ps

package cpts_pkg;

    localparam int CNT_W  = 9;
    localparam int PRIO_W = 8;
    localparam int OUT_W  = 4;

    localparam logic [CNT_W-1:0]  INIT_SLICE = 9'd5;
    localparam logic [PRIO_W-1:0] INIT_PRIO  = 8'd5;
    localparam logic [CNT_W-1:0]  NEW_SLICE  = 9'd15;

    // request command codes
    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_SCHED  = 2'd1,
        CMD_CREATE = 2'd2
    } cmd_t;

    // what a slot table read is for
    typedef enum logic [1:0] {
        RD_SCAN   = 2'd0,
        RD_RECALC = 2'd1,
        RD_TICK   = 2'd2
    } rd_mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK_RD,
        S_TICK_WB,
        S_SCAN,
        S_SCAN_END,
        S_DECIDE,
        S_RECALC,
        S_RECALC_END,
        S_CREATE,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic     start;
        logic     rd_en;
        rd_mode_t rd_mode;
        logic     commit;
        logic     crt_write;
        logic     crt_full;
        logic     load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic tick_need;
        logic found;
        logic slot_free;
    } dp_stat_t;

endpackage

FILE: design/cpts_dp.sv
// Datapath: slot table memory, running flags, best-slot search and result register.
`timescale 1ns / 1ps

module cpts_dp
    import cpts_pkg::*;
#(
    parameter int TASKS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dp_cmd_t                   cmd,
    input  logic [$clog2(TASKS)-1:0]  addr,
    input  logic [PRIO_W-1:0]         new_priority,
    output dp_stat_t                  stat,
    output logic [OUT_W-1:0]          current_task,
    output logic                      switched,
    output logic [OUT_W-1:0]          created_slot,
    output logic                      table_full
);

    localparam int IW = $clog2(TASKS);
    localparam int WW = PRIO_W + CNT_W;

    // slot table: {priority, count}; entries not yet written read as reset value
    logic [WW-1:0]    slot_mem [TASKS];
    logic [TASKS-1:0] valid_reg;
    logic [TASKS-1:0] run_reg;

    logic [IW-1:0]     cur_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic              sw_reg;
    logic [IW-1:0]     made_reg;
    logic              full_reg;

    // read pipeline
    logic [WW-1:0]  rd_q_reg;
    logic           rd_vld_reg;
    logic [IW-1:0]  rd_idx_reg;
    rd_mode_t       rd_mode_reg;
    logic           rd_act_reg;

    // search result
    logic [IW-1:0]    best_reg;
    logic [CNT_W-1:0] top_reg;
    logic             found_reg;

    // result register
    logic [OUT_W-1:0] task_out_reg;
    logic             sw_out_reg;
    logic [OUT_W-1:0] made_out_reg;
    logic             full_out_reg;

    logic [IW-1:0]     rd_addr;
    logic [CNT_W-1:0]  eff_cnt;
    logic [PRIO_W-1:0] eff_prio;
    logic [CNT_W-1:0]  half_sum;
    logic              do_scan;
    logic              do_recalc;
    logic              do_tick;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [WW-1:0]     wr_data;
    logic [IW+OUT_W-1:0] cur_ext;
    logic [IW+OUT_W-1:0] made_ext;

    // tick reads the current slot, everything else the sequencer address
    assign rd_addr = (cmd.rd_mode == RD_TICK) ? cur_reg : addr;

    // effective entry seen by the processing stage
    always_comb
    begin
        if (rd_vld_reg)
        begin
            eff_prio = rd_q_reg[WW-1:CNT_W];
            eff_cnt  = rd_q_reg[CNT_W-1:0];
        end
        else if (rd_idx_reg == '0)
        begin
            eff_prio = INIT_PRIO;
            eff_cnt  = INIT_SLICE;
        end
        else
        begin
            eff_prio = '0;
            eff_cnt  = '0;
        end
    end

    // count/2 + priority stays below 511
    assign half_sum  = (eff_cnt >> 1) + CNT_W'(eff_prio);
    assign do_scan   = rd_act_reg && (rd_mode_reg == RD_SCAN);
    assign do_recalc = rd_act_reg && (rd_mode_reg == RD_RECALC);
    assign do_tick   = rd_act_reg && (rd_mode_reg == RD_TICK);

    // single write port
    always_comb
    begin
        wr_en   = do_recalc || (do_tick && (eff_cnt != '0)) || cmd.crt_write;
        wr_addr = rd_idx_reg;
        wr_data = {eff_prio, eff_cnt - CNT_W'(1)};
        if (cmd.crt_write)
        begin
            wr_addr = addr;
            wr_data = {prio_reg, NEW_SLICE};
        end
        else if (do_recalc)
        begin
            wr_data = {eff_prio, half_sum};
        end
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_q_reg <= slot_mem[rd_addr];
        end
    end

    // read pipeline tags
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_vld_reg  <= valid_reg[rd_addr];
            rd_idx_reg  <= rd_addr;
            rd_mode_reg <= cmd.rd_mode;
        end
    end

    // control flags of the table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            run_reg    <= TASKS'(1);
            cur_reg    <= '0;
            rd_act_reg <= 1'b0;
        end
        else
        begin
            rd_act_reg <= cmd.rd_en;
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.crt_write)
            begin
                run_reg[addr] <= 1'b1;
            end
            if (cmd.commit)
            begin
                cur_reg <= best_reg;
            end
        end
    end

    // best slot search; a scan from slot 0 starts afresh
    always_ff @(posedge clk)
    begin
        if (do_scan && run_reg[rd_idx_reg] && (eff_cnt > top_reg))
        begin
            top_reg   <= eff_cnt;
            best_reg  <= rd_idx_reg;
            found_reg <= 1'b1;
        end
        if (cmd.rd_en && (cmd.rd_mode == RD_SCAN) && (addr == '0))
        begin
            top_reg   <= '0;
            found_reg <= 1'b0;
        end
    end

    // per-request result bits
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            prio_reg <= new_priority;
            sw_reg   <= 1'b0;
            made_reg <= '0;
            full_reg <= 1'b0;
        end
        if (cmd.commit)
        begin
            sw_reg <= (best_reg != cur_reg);
        end
        if (cmd.crt_write)
        begin
            made_reg <= addr;
        end
        if (cmd.crt_full)
        begin
            full_reg <= 1'b1;
        end
    end

    // low bits of the slot indexes
    assign cur_ext  = {{OUT_W{1'b0}}, cur_reg};
    assign made_ext = {{OUT_W{1'b0}}, made_reg};

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            task_out_reg <= cur_ext[OUT_W-1:0];
            sw_out_reg   <= sw_reg;
            made_out_reg <= made_ext[OUT_W-1:0];
            full_out_reg <= full_reg;
        end
    end

    // status; a tick leaves count zero when it read zero or one
    assign stat.tick_need = do_tick && (!run_reg[rd_idx_reg] || (eff_cnt <= CNT_W'(1)));
    assign stat.found     = found_reg;
    assign stat.slot_free = !run_reg[addr];

    assign current_task = task_out_reg;
    assign switched     = sw_out_reg;
    assign created_slot = made_out_reg;
    assign table_full   = full_out_reg;

endmodule

FILE: design/cpts_ctrl.sv
// Controller: sequencer for tick, schedule and create requests and the output handshake.
`timescale 1ns / 1ps

module cpts_ctrl
    import cpts_pkg::*;
#(
    parameter int TASKS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                command,
    output logic                      out_valid,
    input  logic                      out_stall,
    input  dp_stat_t                  stat,
    output dp_cmd_t                   cmd,
    output logic [$clog2(TASKS)-1:0]  addr
);

    localparam int IW = $clog2(TASKS);
    localparam logic [IW-1:0] LAST = IW'(TASKS - 1);

    state_t        state_reg, state_next;
    logic [IW-1:0] addr_reg, addr_next;
    logic          second_reg, second_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        second_next = second_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd_t'(command))
                        CMD_TICK:
                        begin
                            state_next = S_TICK_RD;
                        end
                        CMD_SCHED:
                        begin
                            state_next  = S_SCAN;
                            addr_next   = '0;
                            second_next = 1'b0;
                        end
                        CMD_CREATE:
                        begin
                            state_next = S_CREATE;
                            addr_next  = IW'(1);
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_TICK_RD:
            begin
                state_next = S_TICK_WB;
            end
            S_TICK_WB:
            begin
                if (stat.tick_need)
                begin
                    state_next  = S_SCAN;
                    addr_next   = '0;
                    second_next = 1'b0;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                addr_next = addr_reg + IW'(1);
                if (addr_reg == LAST)
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (stat.found || second_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_RECALC;
                    addr_next  = '0;
                end
            end
            S_RECALC:
            begin
                addr_next = addr_reg + IW'(1);
                if (addr_reg == LAST)
                begin
                    state_next = S_RECALC_END;
                end
            end
            S_RECALC_END:
            begin
                state_next  = S_SCAN;
                addr_next   = '0;
                second_next = 1'b1;
            end
            S_CREATE:
            begin
                if (stat.slot_free || (addr_reg == LAST))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    addr_next = addr_reg + IW'(1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd = '{start: 1'b0, rd_en: 1'b0, rd_mode: RD_SCAN, commit: 1'b0,
                crt_write: 1'b0, crt_full: 1'b0, load_out: 1'b0};
        case (state_reg)
            S_IDLE:
            begin
                cmd.start = in_valid;
            end
            S_TICK_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_mode = RD_TICK;
            end
            S_SCAN:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_mode = RD_SCAN;
            end
            S_RECALC:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_mode = RD_RECALC;
            end
            S_DECIDE:
            begin
                cmd.commit = stat.found;
            end
            S_CREATE:
            begin
                cmd.crt_write = stat.slot_free;
                cmd.crt_full  = !stat.slot_free && (addr_reg == LAST);
            end
            S_DONE:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                cmd.start = 1'b0;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            addr_reg      <= '0;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            second_reg    <= second_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign addr      = addr_reg;

endmodule

FILE: design/counter_priority_task_scheduler.sv
// Top level of the counter priority task scheduler.
//
//  channel  direction  handshake             payload
//  request  in         in_valid / in_stall   command, new_priority
//  result   out        out_valid / out_stall current_task, switched, created_slot, table_full
//
// One request at a time; the next one is taken while a result waits in the output register.
// Tick without reschedule: the current slot is read and written back, then the result is loaded.
// Create: one running flag looked at per cycle, from slot 1 up. Schedule: one slot table read per
// cycle on the single memory port over every slot; when no running slot has a nonzero count a
// recompute pass and a second scan follow.
// Reset clears per-slot valid bits at once; no clearing pass is run.
// out_stall only holds the finished result; the sequencer waits in its last state for room.
`timescale 1ns / 1ps

module counter_priority_task_scheduler
    import cpts_pkg::*;
#(
    parameter int TASKS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        command,
    input  logic [PRIO_W-1:0] new_priority,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [OUT_W-1:0]  current_task,
    output logic              switched,
    output logic [OUT_W-1:0]  created_slot,
    output logic              table_full
);

    localparam int IW = $clog2(TASKS);

    dp_cmd_t       dp_cmd;
    dp_stat_t      dp_stat;
    logic [IW-1:0] seq_addr;

    cpts_ctrl #(
        .TASKS (TASKS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (dp_stat),
        .cmd       (dp_cmd),
        .addr      (seq_addr)
    );

    cpts_dp #(
        .TASKS (TASKS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .addr         (seq_addr),
        .new_priority (new_priority),
        .stat         (dp_stat),
        .current_task (current_task),
        .switched     (switched),
        .created_slot (created_slot),
        .table_full   (table_full)
    );

    // a taken request blocks the next one until its result is loaded
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while busy");

    // a full table never reports a slot
    a_full_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_full |-> created_slot == '0)
        else $error("table full with a created slot");

    // a switch only comes from a tick or schedule request
    a_switch_not_create: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && switched |-> created_slot == '0 && !table_full)
        else $error("switch reported with create result");

    // result is loaded only from the final sequencer state
    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.load_out |-> dp_cmd.rd_en == 1'b0 && dp_cmd.commit == 1'b0)
        else $error("result loaded while work in flight");

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the counter priority task scheduler.
`timescale 1ns / 1ps

module testbench;
    import cpts_pkg::*;

    localparam int          SLOTS          = 16;
    localparam logic [1:0]  CMD_UNUSED     = 2'd3;
    localparam int          HOLD_LEN       = 300;
    localparam int          SETTLE_CYCLES  = 80;
    localparam int          WATCHDOG_LIMIT = 4000;

    // one result of the block, field by field
    typedef struct packed {
        logic [OUT_W-1:0] current_task;
        logic             switched;
        logic [OUT_W-1:0] created_slot;
        logic             table_full;
    } sched_result_t;

    // Slot table predictor plus queue of results still owed by the block
    class sched_scoreboard;
        bit                slot_live[SLOTS];
        logic [CNT_W-1:0]  slot_slice[SLOTS];
        logic [PRIO_W-1:0] slot_prio[SLOTS];
        int                cur_slot;
        sched_result_t     expected_q[$];
        int                mismatches;

        function new();
            for (int k = 0; k < SLOTS; k++)
            begin
                slot_live[k]  = 1'b0;
                slot_slice[k] = '0;
                slot_prio[k]  = '0;
            end
            slot_live[0]  = 1'b1;
            slot_slice[0] = INIT_SLICE;
            slot_prio[0]  = INIT_PRIO;
            cur_slot      = 0;
            mismatches    = 0;
        endfunction

        // running slot with the largest nonzero slice, lowest index on a tie; SLOTS if none
        function int best_slot();
            int               best;
            logic [CNT_W-1:0] top;
            best = SLOTS;
            top  = '0;
            for (int k = 0; k < SLOTS; k++)
            begin
                if (slot_live[k] && slot_slice[k] > top)
                begin
                    top  = slot_slice[k];
                    best = k;
                end
            end
            return best;
        endfunction

        // pick the next task, refilling every slice once when all are spent
        function bit reschedule_slots();
            int next;
            next = best_slot();
            if (next >= SLOTS)
            begin
                for (int k = 0; k < SLOTS; k++)
                    slot_slice[k] = (slot_slice[k] >> 1) + {1'b0, slot_prio[k]};
                next = best_slot();
            end
            if (next >= SLOTS || next == cur_slot)
                return 1'b0;
            cur_slot = next;
            return 1'b1;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // accepted request: update the table and queue the result it causes
        function void note_request(logic [1:0] cmd, logic [PRIO_W-1:0] prio);
            sched_result_t res;
            res = '0;
            case (cmd)
                CMD_TICK:
                begin
                    if (slot_slice[cur_slot] != 0)
                        slot_slice[cur_slot] = slot_slice[cur_slot] - 1'b1;
                    if (!slot_live[cur_slot] || slot_slice[cur_slot] == 0)
                        res.switched = reschedule_slots();
                end
                CMD_SCHED:
                    res.switched = reschedule_slots();
                CMD_CREATE:
                begin
                    res.table_full = 1'b1;
                    for (int k = 1; k < SLOTS; k++)
                    begin
                        if (!slot_live[k])
                        begin
                            slot_live[k]     = 1'b1;
                            slot_slice[k]    = NEW_SLICE;
                            slot_prio[k]     = prio;
                            res.created_slot = k[OUT_W-1:0];
                            res.table_full   = 1'b0;
                            break;
                        end
                    end
                end
                default: ;
            endcase
            res.current_task = cur_slot[OUT_W-1:0];
            expected_q.push_back(res);
        endfunction

        task report(string msg);
            $display("%0t ns mismatch: %s", $time, msg);
            mismatches++;
        endtask

        // compare one accepted result against the oldest expectation
        task check_result(sched_result_t got);
            sched_result_t want;
            if (expected_q.size() == 0)
            begin
                report("result with no request outstanding");
                return;
            end
            want = expected_q.pop_front();
            if (got.current_task !== want.current_task)
                report($sformatf("current_task %0d, expected %0d",
                                 got.current_task, want.current_task));
            if (got.switched !== want.switched)
                report($sformatf("switched %b, expected %b", got.switched, want.switched));
            if (got.created_slot !== want.created_slot)
                report($sformatf("created_slot %0d, expected %0d",
                                 got.created_slot, want.created_slot));
            if (got.table_full !== want.table_full)
                report($sformatf("table_full %b, expected %b",
                                 got.table_full, want.table_full));
        endtask
    endclass

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic [1:0]        command      = '0;
    logic [PRIO_W-1:0] new_priority = '0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic [OUT_W-1:0]  current_task;
    logic              switched;
    logic [OUT_W-1:0]  created_slot;
    logic              table_full;

    sched_scoreboard board;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_request  = 1'b0;
    int  hold_left     = 0;
    int  stuck_cycles  = 0;

    counter_priority_task_scheduler #(.TASKS(SLOTS)) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .new_priority (new_priority),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .current_task (current_task),
        .switched     (switched),
        .created_slot (created_slot),
        .table_full   (table_full)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side back-pressure: random stalls, or a long hold-off when asked
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_LEN;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // result checking and watchdog on handshake activity
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_result({current_task, switched, created_slot, table_full});
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL counter_priority_task_scheduler");
                $finish;
            end
        end
    end

    // offer one request, with random idle cycles ahead of it, until accepted
    task automatic send_request(input logic [1:0] cmd, input logic [PRIO_W-1:0] prio);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        new_priority <= prio;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_request(cmd, prio);
    endtask

    // stop offering and wait until every owed result has come back
    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // random request mix; small priorities half the time to force frequent refills
    task automatic run_random(input int send_pct, input int recv_pct, input int items);
        int                counted;
        int                pick;
        logic [1:0]        cmd;
        logic [PRIO_W-1:0] prio;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        counted       = 0;
        while (counted < items)
        begin
            pick = $urandom_range(99);
            if (pick < 58)
                cmd = CMD_TICK;
            else if (pick < 74)
                cmd = CMD_SCHED;
            else if (pick < 96)
                cmd = CMD_CREATE;
            else
                cmd = CMD_UNUSED;
            if ($urandom_range(1) == 0)
                prio = PRIO_W'($urandom_range(7));
            else
                prio = PRIO_W'($urandom_range(255));
            send_request(cmd, prio);
            if (cmd != CMD_UNUSED)
                counted++;
        end
    endtask

    initial
    begin
        board = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: idle schedule, unused code, slice run-out with refill, creates
        send_idle_pct = 26;
        recv_idle_pct = 70;
        send_request(CMD_SCHED, 8'hFF);
        send_request(CMD_UNUSED, 8'hAA);
        repeat (5) send_request(CMD_TICK, 8'h55);
        send_request(CMD_TICK, 8'h00);
        send_request(CMD_CREATE, 8'hFF);
        send_request(CMD_CREATE, 8'h00);
        send_request(CMD_CREATE, 8'hAA);
        send_request(CMD_CREATE, 8'h55);
        send_request(CMD_SCHED, 8'h00);
        repeat (3) send_request(CMD_TICK, 8'hFF);
        send_request(CMD_UNUSED, 8'h55);
        send_request(CMD_SCHED, 8'hAA);
        wait_for_results();

        // random phases: slow receiver, then slow sender
        run_random(26, 70, 570);
        wait_for_results();
        run_random(70, 26, 570);
        wait_for_results();

        // no idling, opened by a long result hold-off so the block backs up
        hold_request = 1'b1;
        run_random(0, 0, 560);
        wait_for_results();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("PASS counter_priority_task_scheduler");
        else
            $display("FAIL counter_priority_task_scheduler");
        $finish;
    end

endmodule

FILE: sim.f
design/cpts_pkg.sv
design/cpts_dp.sv
design/cpts_ctrl.sv
design/counter_priority_task_scheduler.sv
sim/testbench.sv
